// ===== hw/rtl/hmre_pkg.sv =====
// Shared types and constants for the mouse report event decoder.
package hmre_pkg;

  localparam int unsigned NumButtons = 5;
  localparam int unsigned NumSlots   = 15;
  localparam int unsigned SlotW      = $clog2(NumSlots);

  localparam logic [7:0] ReportIdReset = 8'h01;

  // Fixed event order within one report.
  localparam logic [SlotW-1:0] SlotWheel     = SlotW'(0);
  localparam logic [SlotW-1:0] SlotWheelSync = SlotW'(1);
  localparam logic [SlotW-1:0] SlotX         = SlotW'(2);
  localparam logic [SlotW-1:0] SlotY         = SlotW'(3);
  localparam logic [SlotW-1:0] SlotMotSync   = SlotW'(4);
  localparam logic [SlotW-1:0] SlotBtnBase   = SlotW'(5);

  typedef enum logic [1:0] {
    EVT_SYNC = 2'd0,
    EVT_KEY  = 2'd1,
    EVT_REL  = 2'd2
  } evt_type_e;

  typedef enum logic [2:0] {
    REL_CODE_X     = 3'd0,
    REL_CODE_Y     = 3'd1,
    REL_CODE_WHEEL = 3'd2
  } rel_code_e;

  localparam logic [2:0] SyncCode = 3'd0;

  // One decoded report: which event slots fire, plus their payloads.
  typedef struct packed {
    logic [NumSlots-1:0]   mask;
    logic [15:0]           dx;
    logic [15:0]           dy;
    logic [15:0]           wheel;
    logic [NumButtons-1:0] press;
  } ev_slots_t;

endpackage

// ===== hw/rtl/hid_mouse_report_to_events_unit.sv =====
// Top level: mouse report in, stream of input events out.
//
// Usage notes
// - Slave stream (s_axis_*): one seven-byte mouse report per transaction; the
//   valid flag of the transfer rides in tuser. Invalid reports and reports whose
//   ID byte differs from the configured ID are consumed and produce nothing.
// - Master stream (m_axis_*): one event per transaction, event type in tuser,
//   code and value in tdata, tlast on the final event of a report.
// - Config channel (cfg_*): writes the expected report ID; always ready. Write
//   it only while the block is idle.
// - Path: the first event of a report moves from the pending slot register
//   to the output register on its way out. A report yields 0 to 15 events,
//   drained one per cycle while the master side is ready.
// - Throughput: a report producing events holds the pending slot register
//   until its last event moves to the output register; the next report is
//   taken in that cycle, so reports with no events are taken every cycle.
// - Stall: when m_axis_tready is low the output register holds its event and
//   the pending slots wait; s_axis_tready drops once slots remain.
// - Reset: no events pending, all buttons released, report ID back to 1.
module hid_mouse_report_to_events_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // report stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: report_id, button_mask, dx_low, dx_high, dy_low, dy_high, wheel_byte
  input  logic [55:0] s_axis_tdata,
  // tuser: report_valid
  input  logic        s_axis_tuser,
  // event stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: event_code [2:0], event_value [18:3], zero pad [23:19]
  output logic [23:0] m_axis_tdata,
  // tuser: event_type
  output logic [1:0]  m_axis_tuser,
  output logic        m_axis_tlast,
  // config write
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i
);
  import hmre_pkg::*;

  logic [7:0]            exp_id_q;
  logic [NumButtons-1:0] held_q, held_d;
  ev_slots_t             slots_d;
  ev_slots_t             pend_q;

  logic                  in_acc;
  logic                  out_load;
  logic                  pop;
  logic [NumSlots-1:0]   sel_hot;
  logic [NumSlots-1:0]   rem;
  logic [SlotW-1:0]      sel_idx;
  logic [SlotW-1:0]      btn_off;
  logic [2:0]            btn;

  evt_type_e             ev_type;
  logic [2:0]            ev_code;
  logic [15:0]           ev_value;

  logic                  out_valid_q;
  evt_type_e             out_type_q;
  logic [2:0]            out_code_q;
  logic [15:0]           out_value_q;
  logic                  out_last_q;

  // Config register.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_id_q <= ReportIdReset;
    end else if (cfg_valid_i) begin
      exp_id_q <= cfg_data_i;
    end
  end

  hmre_decode u_decode (
    .valid_i       (s_axis_tuser),
    .report_id_i   (s_axis_tdata[7:0]),
    .expected_id_i (exp_id_q),
    .button_mask_i (s_axis_tdata[15:8]),
    .dx_i          (s_axis_tdata[31:16]),
    .dy_i          (s_axis_tdata[47:32]),
    .wheel_i       (s_axis_tdata[55:48]),
    .held_i        (held_q),
    .slots_o       (slots_d),
    .held_o        (held_d)
  );

  // Next event: lowest pending slot, moved out whenever the output register is free.
  assign out_load = !out_valid_q || m_axis_tready;
  assign pop      = out_load && (pend_q.mask != '0);
  assign sel_hot  = pend_q.mask & (~pend_q.mask + NumSlots'(1));
  assign rem      = pend_q.mask & ~sel_hot;

  always_comb begin
    sel_idx = '0;
    for (int s = 0; s < NumSlots; s++) begin
      if (sel_hot[s]) sel_idx = sel_idx | SlotW'(s);
    end
  end

  // A new report may enter once the slot register is empty or drains this cycle.
  assign s_axis_tready = (pend_q.mask == '0) || (pop && (rem == '0));
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // Button slots come in key/sync pairs.
  assign btn_off = sel_idx - SlotBtnBase;
  assign btn     = 3'(btn_off[SlotW-1:1]);

  always_comb begin
    ev_type  = EVT_SYNC;
    ev_code  = SyncCode;
    ev_value = '0;
    priority if (sel_idx == SlotWheel) begin
      ev_type  = EVT_REL;
      ev_code  = REL_CODE_WHEEL;
      ev_value = pend_q.wheel;
    end else if (sel_idx == SlotX) begin
      ev_type  = EVT_REL;
      ev_code  = REL_CODE_X;
      ev_value = pend_q.dx;
    end else if (sel_idx == SlotY) begin
      ev_type  = EVT_REL;
      ev_code  = REL_CODE_Y;
      ev_value = pend_q.dy;
    end else if (sel_idx >= SlotBtnBase && !btn_off[0]) begin
      ev_type  = EVT_KEY;
      ev_code  = btn;
      ev_value = {15'd0, pend_q.press[btn]};
    end else begin
      ev_type  = EVT_SYNC;
    end
  end

  // Pending slot register and button state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      held_q <= '0;
    end else if (in_acc) begin
      pend_q <= slots_d;
      held_q <= held_d;
    end else if (pop) begin
      pend_q.mask <= rem;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= pop;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      out_type_q  <= ev_type;
      out_code_q  <= ev_code;
      out_value_q <= ev_value;
      out_last_q  <= (rem == '0);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_type_q;
  assign m_axis_tdata  = {5'd0, out_value_q, out_code_q};
  assign m_axis_tlast  = out_last_q;

`ifndef ASSERT_OFF
  // Whenever events are pending, the output register holds a valid event next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q.mask != '0) |=> m_axis_tvalid)
    else $error("pending events but output register empty");

  // Button state only moves when a report is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_acc |=> $stable(held_q))
    else $error("button state changed without a report");

  // Sync events carry code 0 and value 0.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == EVT_SYNC) |->
      (m_axis_tdata[18:0] == 19'd0))
    else $error("sync event with nonzero payload");

  // A report is only taken once the slot register has been drained.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> (rem == '0))
    else $error("report accepted over pending events");
`endif

endmodule

// ===== hw/rtl/hmre_decode.sv =====
// Report decoder: checks the report, builds the event slot set and next button state.
module hmre_decode (
  input  logic                           valid_i,
  input  logic [7:0]                     report_id_i,
  input  logic [7:0]                     expected_id_i,
  input  logic [7:0]                     button_mask_i,
  input  logic [15:0]                    dx_i,
  input  logic [15:0]                    dy_i,
  input  logic [7:0]                     wheel_i,
  input  logic [hmre_pkg::NumButtons-1:0] held_i,
  output hmre_pkg::ev_slots_t            slots_o,
  output logic [hmre_pkg::NumButtons-1:0] held_o
);
  import hmre_pkg::*;

  logic                  take;
  logic [NumButtons-1:0] pressed;
  logic [NumButtons-1:0] change;

  assign take    = valid_i && (report_id_i == expected_id_i);
  assign pressed = button_mask_i[NumButtons-1:0];
  assign change  = pressed ^ held_i;

  always_comb begin
    slots_o       = '0;
    slots_o.dx    = dx_i;
    slots_o.dy    = dy_i;
    slots_o.wheel = {{8{wheel_i[7]}}, wheel_i};
    slots_o.press = pressed;
    if (take) begin
      slots_o.mask[SlotWheel]     = (wheel_i != 8'd0);
      slots_o.mask[SlotWheelSync] = (wheel_i != 8'd0);
      slots_o.mask[SlotX]         = (dx_i != 16'd0);
      slots_o.mask[SlotY]         = (dy_i != 16'd0);
      slots_o.mask[SlotMotSync]   = (dx_i != 16'd0) || (dy_i != 16'd0);
      for (int b = 0; b < NumButtons; b++) begin
        slots_o.mask[int'(SlotBtnBase) + 2*b]     = change[b];
        slots_o.mask[int'(SlotBtnBase) + 2*b + 1] = change[b];
      end
    end
  end

  // Every differing button gets its event, so the held state ends at the new mask.
  assign held_o = take ? pressed : held_i;

endmodule
